>>> hdl/cbm_pkg.sv
package cbm_pkg;

    // Queue between the decode front and the mapper back end
    localparam int QUEUE_DEPTH = 2;

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 9;

    localparam logic [CFG_INDEX_W-1:0] CFG_ROM_BANK_COUNT = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_HANDHELD_MODE  = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_BIOS_ENABLED   = 2'd2;

    localparam logic [8:0] ROM_BANK_COUNT_RST = 9'd32;

    localparam logic [1:0] MODE_MEM_READ  = 2'd0;
    localparam logic [1:0] MODE_MEM_WRITE = 2'd1;
    localparam logic [1:0] MODE_CTRL_PORT = 2'd2;

    localparam logic [2:0] TGT_ROM  = 3'd0;
    localparam logic [2:0] TGT_BIOS = 3'd1;
    localparam logic [2:0] TGT_RAM  = 3'd2;
    localparam logic [2:0] TGT_SRAM = 3'd3;
    localparam logic [2:0] TGT_NONE = 3'd4;

    localparam logic [4:0] BANK_RST [4] = '{5'd0, 5'd0, 5'd1, 5'd0};

    typedef struct packed {
        logic [1:0]  mode;
        logic [15:0] address;
        logic [7:0]  data;
    } cbm_in_t;

    typedef struct packed {
        logic [2:0]  target;
        logic [18:0] offset;
        logic        write_strobe;
        logic [7:0]  write_data;
        logic        sram_dirty;
    } cbm_out_t;

    // Access class, decided from mode and address alone
    typedef enum logic [2:0] {
        CLS_NOP,
        CLS_RD_LOW,
        CLS_RD_WINDOW,
        CLS_RD_RAM,
        CLS_WR_RAM,
        CLS_WR_UPPER,
        CLS_CTRL
    } cbm_cls_t;

    typedef struct packed {
        cbm_cls_t    cls;
        logic        bank_load;
        logic [15:0] address;
        logic [7:0]  data;
    } cbm_op_t;

endpackage

>>> hdl/cbm_front.sv
module cbm_front
    import cbm_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    s_valid,
    output logic    s_ready,
    input  cbm_in_t s_data,
    output logic    op_valid,
    input  logic    op_ready,
    output cbm_op_t op_data
);

    logic    valid_reg, valid_next;
    cbm_op_t op_reg;
    cbm_op_t op_next;
    logic    s_fire;

    assign s_ready = !valid_reg || op_ready;
    assign s_fire  = s_valid && s_ready;

    always_comb begin
        op_next.address   = s_data.address;
        op_next.data      = s_data.data;
        op_next.bank_load = (s_data.address[15:2] == 14'h3fff);
        op_next.cls       = CLS_NOP;
        unique case (s_data.mode)
            MODE_MEM_READ: begin
                if (s_data.address[15:10] == 6'd0) begin
                    op_next.cls = CLS_RD_LOW;
                end else if (s_data.address[15:14] == 2'b11) begin
                    op_next.cls = CLS_RD_RAM;
                end else begin
                    op_next.cls = CLS_RD_WINDOW;
                end
            end
            MODE_MEM_WRITE: begin
                if (s_data.address[15:14] == 2'b11) begin
                    op_next.cls = CLS_WR_RAM;
                end else if (s_data.address[15]) begin
                    op_next.cls = CLS_WR_UPPER;
                end else begin
                    op_next.cls = CLS_NOP;
                end
            end
            MODE_CTRL_PORT: op_next.cls = CLS_CTRL;
            default:        op_next.cls = CLS_NOP;
        endcase
    end

    always_comb begin
        valid_next = valid_reg;
        if (s_fire) begin
            valid_next = 1'b1;
        end else if (op_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
        if (s_fire) begin
            op_reg <= op_next;
        end
    end

    assign op_valid = valid_reg;
    assign op_data  = op_reg;

endmodule

>>> hdl/cbm_queue.sv
module cbm_queue
    import cbm_pkg::*;
#(
    parameter int Depth = QUEUE_DEPTH
)
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    in_valid,
    output logic    in_ready,
    input  cbm_op_t in_data,
    output logic    out_valid,
    input  logic    out_ready,
    output cbm_op_t out_data
);

    localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
    localparam int CntW = $clog2(Depth + 1);

    cbm_op_t         mem_reg [Depth];
    logic [PtrW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PtrW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CntW-1:0] count_reg, count_next;
    logic            push, pop;

    assign in_ready  = (count_reg != CntW'(Depth));
    assign out_valid = (count_reg != '0);
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;
    assign out_data  = mem_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PtrW'(Depth - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PtrW'(Depth - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
        if (push) begin
            mem_reg[wr_ptr_reg] <= in_data;
        end
    end

    assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CntW'(Depth))
        else $error("queue count beyond depth");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (count_reg == '0) |-> (wr_ptr_reg == rd_ptr_reg))
        else $error("empty queue with unequal pointers");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (push && !pop) |=> (count_reg == $past(count_reg) + 1'b1))
        else $error("queue count missed a push");

endmodule

>>> hdl/cbm_back.sv
module cbm_back
    import cbm_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   cfg_valid,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    input  logic                   op_valid,
    output logic                   op_ready,
    input  cbm_op_t                op_data,
    output logic                   m_valid,
    input  logic                   m_ready,
    output cbm_out_t               m_data
);

    logic [8:0] bank_count_reg;
    logic       handheld_reg;
    logic       bios_en_reg;

    logic [4:0] rom_banks_reg  [4];
    logic [4:0] rom_banks_next [4];
    logic [4:0] bios_banks_reg  [4];
    logic [4:0] bios_banks_next [4];
    logic       rom_active_reg, rom_active_next;
    logic [7:0] mem_ctrl_reg, mem_ctrl_next;
    logic       sram_wr_reg, sram_wr_next;

    logic       out_valid_reg, out_valid_next;
    cbm_out_t   out_reg;
    cbm_out_t   out_next;
    logic       pop;

    logic       use_rom_set;
    logic [4:0] bank0;
    logic [1:0] win_idx;
    logic [4:0] win_bank;
    logic [4:0] bank_mask;
    logic [4:0] page_bank;
    logic [18:0] page_base;
    logic       page_oob;
    logic [18:0] win_offset;
    logic [18:0] sram_off;
    logic       sram_mapped;
    logic [15:0] a;

    assign op_ready = !out_valid_reg || m_ready;
    assign pop      = op_valid && op_ready;
    assign a        = op_data.address;

    // Translation against the current register values
    always_comb begin
        use_rom_set = rom_active_reg || handheld_reg;
        bank0       = use_rom_set ? rom_banks_reg[0] : bios_banks_reg[0];
        win_idx     = a[15:14] + 2'd1;
        win_bank    = use_rom_set ? rom_banks_reg[win_idx] : bios_banks_reg[win_idx];
        bank_mask   = 5'(bank_count_reg - 9'd1);
        page_bank   = win_bank & bank_mask;
        page_base   = {page_bank, a[13:10], 10'd0};
        page_oob    = ({4'd0, page_base} >= {bank_count_reg, 14'd0})
                      && (mem_ctrl_reg[3] || handheld_reg);
        win_offset  = page_oob ? {9'd0, a[9:0]} : {page_bank, a[13:0]};
        sram_off    = {4'd0, bank0[2], 1'b0, a[12:0]};
        sram_mapped = bank0[3] && a[15];
    end

    always_comb begin
        rom_banks_next  = rom_banks_reg;
        bios_banks_next = bios_banks_reg;
        rom_active_next = rom_active_reg;
        mem_ctrl_next   = mem_ctrl_reg;
        sram_wr_next    = sram_wr_reg;
        out_next.target       = TGT_NONE;
        out_next.offset       = '0;
        out_next.write_strobe = 1'b0;
        out_next.write_data   = '0;
        unique case (op_data.cls)
            CLS_RD_LOW: begin
                out_next.target = TGT_ROM;
                out_next.offset = {9'd0, a[9:0]};
            end
            CLS_RD_WINDOW: begin
                if (sram_mapped) begin
                    out_next.target = TGT_SRAM;
                    out_next.offset = sram_off;
                end else begin
                    out_next.target = (mem_ctrl_reg[6] && !handheld_reg) ? TGT_BIOS : TGT_ROM;
                    out_next.offset = win_offset;
                end
            end
            CLS_RD_RAM: begin
                out_next.target = TGT_RAM;
                out_next.offset = {6'd0, a[12:0]};
            end
            CLS_WR_RAM: begin
                out_next.target       = TGT_RAM;
                out_next.offset       = {6'd0, a[12:0]};
                out_next.write_strobe = 1'b1;
                out_next.write_data   = op_data.data;
                if (pop && op_data.bank_load) begin
                    if (use_rom_set) begin
                        rom_banks_next[a[1:0]] = op_data.data[4:0];
                    end else begin
                        bios_banks_next[a[1:0]] = op_data.data[4:0];
                    end
                end
            end
            CLS_WR_UPPER: begin
                if (bank0[3]) begin
                    out_next.target       = TGT_SRAM;
                    out_next.offset       = sram_off;
                    out_next.write_strobe = 1'b1;
                    out_next.write_data   = op_data.data;
                    if (pop) begin
                        sram_wr_next = 1'b1;
                    end
                end
            end
            CLS_CTRL: begin
                if (pop && bios_en_reg) begin
                    mem_ctrl_next = op_data.data;
                    if (!handheld_reg) begin
                        rom_active_next = op_data.data[3];
                    end
                end
            end
            default: ;
        endcase
        out_next.sram_dirty = sram_wr_next;
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        if (pop) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bank_count_reg <= ROM_BANK_COUNT_RST;
            handheld_reg   <= 1'b0;
            bios_en_reg    <= 1'b1;
            rom_banks_reg  <= BANK_RST;
            bios_banks_reg <= BANK_RST;
            rom_active_reg <= 1'b0;
            mem_ctrl_reg   <= '0;
            sram_wr_reg    <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            if (cfg_valid) begin
                case (cfg_index)
                    CFG_ROM_BANK_COUNT: bank_count_reg <= cfg_data;
                    CFG_HANDHELD_MODE:  handheld_reg   <= cfg_data[0];
                    CFG_BIOS_ENABLED:   bios_en_reg    <= cfg_data[0];
                    default: ;
                endcase
            end
            rom_banks_reg  <= rom_banks_next;
            bios_banks_reg <= bios_banks_next;
            rom_active_reg <= rom_active_next;
            mem_ctrl_reg   <= mem_ctrl_next;
            sram_wr_reg    <= sram_wr_next;
            out_valid_reg  <= out_valid_next;
        end
        if (pop) begin
            out_reg <= out_next;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.write_strobe) |->
            (m_data.target == TGT_RAM || m_data.target == TGT_SRAM))
        else $error("write strobe on a read-only target");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.target == TGT_NONE) |->
            (m_data.offset == '0 && !m_data.write_strobe))
        else $error("dropped access carries offset or strobe");

    assert property (@(posedge aclk) disable iff (!aresetn)
        $past(sram_wr_reg) |-> sram_wr_reg)
        else $error("sram dirty flag cleared without reset");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (pop && op_data.cls == CLS_WR_UPPER && bank0[3]) |=> sram_wr_reg)
        else $error("sram write did not mark dirty");

endmodule

>>> hdl/cartridge_bank_mapper_top.sv
// Channel   Direction  Ports                          Beat
// s_        in         s_valid s_ready s_data         one CPU bus access
// m_        out        m_valid m_ready m_data         one translated access
// cfg_      in         cfg_valid cfg_ready cfg_index  one register write
//
// One beat per cycle while m_ready is high, through the decode register,
// two-entry queue and output register holding the mapper state update.
// Reset is synchronous on aresetn low; bank registers return to 0,0,1,0.
// Either side may stall: the queue and the output register absorb it.
module cartridge_bank_mapper_top
    import cbm_pkg::*;
#(
    parameter int QueueDepth = QUEUE_DEPTH
)
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  cbm_in_t                s_data,
    output logic                   m_valid,
    input  logic                   m_ready,
    output cbm_out_t               m_data,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    logic    f_valid, f_ready;
    cbm_op_t f_op;
    logic    q_valid, q_ready;
    cbm_op_t q_op;

    assign cfg_ready = 1'b1;

    cbm_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_data   (s_data),
        .op_valid (f_valid),
        .op_ready (f_ready),
        .op_data  (f_op)
    );

    cbm_queue #(
        .Depth (QueueDepth)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (f_valid),
        .in_ready  (f_ready),
        .in_data   (f_op),
        .out_valid (q_valid),
        .out_ready (q_ready),
        .out_data  (q_op)
    );

    cbm_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .op_valid  (q_valid),
        .op_ready  (q_ready),
        .op_data   (q_op),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

endmodule

>>> dv/tb_top.sv
module tb_top;
    import cbm_pkg::*;

    localparam logic [1:0] MODE_UNUSED = 2'd3;

    logic                   aclk = 1'b0;
    logic                   aresetn = 1'b0;
    logic                   s_valid = 1'b0;
    logic                   s_ready;
    cbm_in_t                s_data = '0;
    logic                   m_valid;
    logic                   m_ready = 1'b0;
    cbm_out_t               m_data;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;

    cartridge_bank_mapper_top dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // mapper shadow state
    logic [8:0] bank_count;
    logic       handheld;
    logic       bios_en;
    logic [4:0] rom_banks [4];
    logic [4:0] bios_banks [4];
    logic       rom_set_sel;
    logic [7:0] mem_ctrl;
    logic       sram_wr;

    cbm_in_t  access_q [$];
    cbm_out_t xlate_q [$];
    int       n_queued = 0;
    int       n_accepted = 0;
    int       n_errors = 0;
    int       in_gap = 0;
    int       out_gap = 0;
    logic     idle_en = 1'b1;
    logic     in_taken = 1'b0;

    function automatic logic [4:0] active_bank(input logic [1:0] idx);
        return (rom_set_sel || handheld) ? rom_banks[idx] : bios_banks[idx];
    endfunction

    function automatic logic [18:0] window_offset(input logic [15:0] a);
        logic [8:0]  mask;
        logic [4:0]  bank;
        logic [22:0] rom_size;
        logic [22:0] base;
        mask = bank_count - 9'd1;
        bank = active_bank(2'(a[15:14] + 2'd1)) & mask[4:0];
        rom_size = {bank_count, 14'd0};
        base = {4'd0, bank, a[13:10], 10'd0};
        // page past the end of ROM folds back to bank 0 when mem_ctrl[3] or handheld is set
        if (base >= rom_size && (mem_ctrl[3] || handheld))
            base = '0;
        return base[18:0] + {9'd0, a[9:0]};
    endfunction

    function automatic cbm_out_t translate(input cbm_in_t acc);
        cbm_out_t   r;
        logic [4:0] b0;
        logic [15:0] a;
        r = '0;
        r.target = TGT_NONE;
        a = acc.address;
        b0 = active_bank(2'd0);
        case (acc.mode)
            MODE_MEM_READ: begin
                if (a < 16'h0400) begin
                    r.target = TGT_ROM;
                    r.offset = {3'd0, a};
                end else if (a < 16'hC000) begin
                    if (b0[3] && a >= 16'h8000) begin
                        r.target = TGT_SRAM;
                        r.offset = {4'd0, b0[2], 1'b0, a[12:0]};
                    end else begin
                        r.target = (mem_ctrl[6] && !handheld) ? TGT_BIOS : TGT_ROM;
                        r.offset = window_offset(a);
                    end
                end else begin
                    r.target = TGT_RAM;
                    r.offset = {6'd0, a[12:0]};
                end
            end
            MODE_MEM_WRITE: begin
                if (a >= 16'hC000) begin
                    r.target = TGT_RAM;
                    r.offset = {6'd0, a[12:0]};
                    r.write_strobe = 1'b1;
                    if (a >= 16'hFFFC) begin
                        if (rom_set_sel || handheld)
                            rom_banks[a[1:0]] = acc.data[4:0];
                        else
                            bios_banks[a[1:0]] = acc.data[4:0];
                    end
                end else if (a >= 16'h8000 && b0[3]) begin
                    r.target = TGT_SRAM;
                    r.offset = {4'd0, b0[2], 1'b0, a[12:0]};
                    r.write_strobe = 1'b1;
                    sram_wr = 1'b1;
                end
            end
            MODE_CTRL_PORT: begin
                if (bios_en) begin
                    mem_ctrl = acc.data;
                    if (!handheld)
                        rom_set_sel = acc.data[3];
                end
            end
            default: ;
        endcase
        r.write_data = r.write_strobe ? acc.data : 8'h00;
        r.sram_dirty = sram_wr;
        return r;
    endfunction

    function automatic cbm_in_t random_access();
        cbm_in_t acc;
        int      pick;
        acc.mode = MODE_MEM_READ;
        acc.address = 16'($urandom);
        acc.data = 8'($urandom);
        pick = $urandom_range(0, 99);
        if (pick < 14) begin
            acc.mode = MODE_MEM_WRITE;
            acc.address = 16'hFFFC | 16'($urandom_range(0, 3));
        end else if (pick < 22) begin
            acc.mode = MODE_CTRL_PORT;
        end else if (pick < 40) begin
            acc.mode = MODE_MEM_WRITE;
            acc.address = {2'b10, 14'($urandom)};
        end else if (pick < 48) begin
            acc.mode = MODE_MEM_WRITE;
        end else if (pick < 52) begin
            acc.mode = MODE_UNUSED;
        end else if (pick < 60) begin
            acc.address = {6'd0, 10'($urandom)};
        end
        return acc;
    endfunction

    task automatic check_field(input string name, input logic [18:0] want,
                               input logic [18:0] got);
        if (got !== want) begin
            if (n_errors < 10)
                $display("mismatch on %s: expected %0h, got %0h", name, want, got);
            n_errors++;
        end
    endtask

    // input side
    always @(negedge aclk) begin
        if (s_valid && !in_taken) begin
            // hold the pending beat
        end else if (in_gap != 0) begin
            s_valid <= 1'b0;
            in_gap <= in_gap - 1;
        end else if (idle_en && $urandom_range(0, 9) == 0) begin
            s_valid <= 1'b0;
            in_gap <= $urandom_range(0, 11);
        end else if (access_q.size() != 0) begin
            s_valid <= 1'b1;
            s_data <= access_q.pop_front();
        end else begin
            s_valid <= 1'b0;
        end
    end

    // result side back-pressure
    always @(negedge aclk) begin
        if (out_gap != 0) begin
            m_ready <= 1'b0;
            out_gap <= out_gap - 1;
        end else if (idle_en && $urandom_range(0, 9) == 0) begin
            m_ready <= 1'b0;
            out_gap <= $urandom_range(0, 11);
        end else begin
            m_ready <= 1'b1;
        end
    end

    always @(posedge aclk) begin : monitor
        cbm_out_t want;
        in_taken = aresetn && s_valid && s_ready;
        if (in_taken) begin
            xlate_q.push_back(translate(s_data));
            n_accepted++;
        end
        if (aresetn && cfg_valid && cfg_ready) begin
            case (cfg_index)
                CFG_ROM_BANK_COUNT: bank_count = cfg_data;
                CFG_HANDHELD_MODE:  handheld = cfg_data[0];
                CFG_BIOS_ENABLED:   bios_en = cfg_data[0];
                default: ;
            endcase
        end
        if (aresetn && m_valid && m_ready) begin
            if (xlate_q.size() == 0) begin
                if (n_errors < 10)
                    $display("result beat with nothing expected: %h", m_data);
                n_errors++;
            end else begin
                want = xlate_q.pop_front();
                check_field("target", 19'(want.target), 19'(m_data.target));
                check_field("offset", want.offset, m_data.offset);
                check_field("write_strobe", 19'(want.write_strobe),
                            19'(m_data.write_strobe));
                check_field("write_data", 19'(want.write_data), 19'(m_data.write_data));
                check_field("sram_dirty", 19'(want.sram_dirty), 19'(m_data.sram_dirty));
            end
        end
    end

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge aclk); while (!(cfg_valid && cfg_ready));
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic push_access(input logic [1:0] mode, input logic [15:0] addr,
                               input logic [7:0] data);
        cbm_in_t acc;
        acc.mode = mode;
        acc.address = addr;
        acc.data = data;
        access_q.push_back(acc);
        n_queued++;
    endtask

    task automatic drain();
        do @(negedge aclk); while (n_accepted != n_queued || xlate_q.size() != 0);
        repeat (6) @(negedge aclk);
    endtask

    task automatic run_phase(input logic [8:0] cnt, input logic hh, input logic be,
                             input int n_items);
        write_reg(CFG_ROM_BANK_COUNT, cnt);
        write_reg(CFG_HANDHELD_MODE, {8'd0, hh});
        write_reg(CFG_BIOS_ENABLED, {8'd0, be});
        repeat (n_items) begin
            access_q.push_back(random_access());
            n_queued++;
        end
        drain();
    endtask

    initial begin
        bank_count = 9'd32;
        handheld = 1'b0;
        bios_en = 1'b1;
        rom_banks = '{5'd0, 5'd0, 5'd1, 5'd0};
        bios_banks = '{5'd0, 5'd0, 5'd1, 5'd0};
        rom_set_sel = 1'b0;
        mem_ctrl = 8'h00;
        sram_wr = 1'b0;

        repeat (4) @(negedge aclk);
        aresetn = 1'b1;

        // directed pass on reset settings
        push_access(MODE_MEM_READ,  16'h0000, 8'h00);
        push_access(MODE_MEM_READ,  16'h03FF, 8'hFF);
        push_access(MODE_MEM_READ,  16'h0400, 8'h00);
        push_access(MODE_MEM_READ,  16'h4000, 8'h00);
        push_access(MODE_MEM_READ,  16'h7FFF, 8'h00);
        push_access(MODE_MEM_READ,  16'h8000, 8'h00);
        push_access(MODE_MEM_READ,  16'hBFFF, 8'h00);
        push_access(MODE_MEM_READ,  16'hC000, 8'h00);
        push_access(MODE_MEM_READ,  16'hFFFF, 8'h00);
        push_access(MODE_MEM_WRITE, 16'h0000, 8'hFF);    // ignored write
        push_access(MODE_MEM_WRITE, 16'hC000, 8'hFF);
        push_access(MODE_MEM_WRITE, 16'hFFFD, 8'hFF);    // bank 1 <- 0x1f
        push_access(MODE_MEM_READ,  16'h0400, 8'h00);
        push_access(MODE_CTRL_PORT, 16'hFFFF, 8'h48);    // BIOS overlay, ROM set
        push_access(MODE_MEM_READ,  16'h4000, 8'h00);
        push_access(MODE_MEM_WRITE, 16'hFFFC, 8'h0C);    // map SRAM, upper half
        push_access(MODE_MEM_WRITE, 16'h8000, 8'hA5);
        push_access(MODE_MEM_READ,  16'hBFFF, 8'h00);
        push_access(MODE_MEM_WRITE, 16'hFFFE, 8'h1F);
        push_access(MODE_MEM_READ,  16'h8001, 8'h00);
        push_access(MODE_CTRL_PORT, 16'h0000, 8'h00);    // back to BIOS set
        push_access(MODE_MEM_READ,  16'h8000, 8'h00);
        push_access(MODE_MEM_WRITE, 16'hBFFF, 8'h5A);    // SRAM unmapped here
        push_access(MODE_UNUSED,    16'hFFFF, 8'hFF);
        push_access(MODE_MEM_WRITE, 16'hFFFF, 8'hE0);
        drain();

        run_phase(9'd256, 1'b0, 1'b1, 150);
        run_phase(9'd1,   1'b0, 1'b1, 150);
        run_phase(9'd0,   1'b0, 1'b1, 160);    // empty ROM: pages fold when folding is on
        run_phase(9'd0,   1'b1, 1'b0, 120);
        run_phase(9'd8,   1'b1, 1'b1, 150);
        run_phase(9'd16,  1'b0, 1'b0, 140);
        run_phase(9'd2,   1'b1, 1'b0, 130);
        run_phase(9'd64,  1'b0, 1'b1, 140);
        run_phase(9'd128, 1'b1, 1'b1, 140);
        idle_en = 1'b0;
        run_phase(9'd32,  1'b0, 1'b1, 150);

        if (n_errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    initial begin
        #5_000_000;
        $display("Some tests failed");
        $finish;
    end

endmodule

>>> filelist.f
hdl/cbm_pkg.sv
hdl/cbm_front.sv
hdl/cbm_queue.sv
hdl/cbm_back.sv
hdl/cartridge_bank_mapper_top.sv
dv/tb_top.sv
